FILE: rtl/cmhd_pkg.sv
// Shared types, constants and fixed-point helpers for the complex mixer
// and halfband decimator. No dependencies.
`timescale 1ns / 1ps

package cmhd_pkg;

  // Oscillator renormalization interval in input samples.
  localparam int unsigned BLOCK_SIZE_DEF = 1024;

  // Halfband filter length and queue depth between front and back.
  localparam int unsigned TAP_COUNT = 11;
  localparam int unsigned QDEPTH    = 2;
  localparam int unsigned QPTR_W    = $clog2(QDEPTH);
  localparam int unsigned QCNT_W    = $clog2(QDEPTH + 1);

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned OSC_W    = 18;
  localparam int unsigned CFG_IDX_W = 4;

  localparam logic signed [OSC_W-1:0] Q17_MAX = 18'sh1FFFF;
  localparam logic signed [OSC_W-1:0] Q17_MIN = 18'sh20000;
  localparam logic signed [SAMPLE_W-1:0] Q15_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] Q15_MIN = 16'sh8000;

  // Halfband taps in Q1.17; the centre tap of one half is a shift by 16.
  localparam logic signed [OSC_W-1:0] COEF_EDGE = 18'sd792;
  localparam logic signed [OSC_W-1:0] COEF_NEAR = -18'sd6471;
  localparam logic signed [OSC_W-1:0] COEF_SIDE = 18'sd38447;
  localparam int unsigned COEF_MID_SHIFT = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_COS = 4'd0,
    CFG_STEP_SIN = 4'd1
  } cfg_idx_e;

  typedef struct packed {
    logic                 valid;
    logic [CFG_IDX_W-1:0] index;
    logic [OSC_W-1:0]     data;
  } cfg_wr_t;

  // One classified input sample as it waits in the queue.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] in_i;
    logic signed [SAMPLE_W-1:0] in_q;
    logic                       renorm;
    logic                       emit;
  } item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RN_SQ,
    ST_RN_GAIN,
    ST_RN_MUL,
    ST_RN_APPLY,
    ST_MUL,
    ST_ACC,
    ST_FIR_MUL,
    ST_FIR_SUM
  } state_e;

  function automatic logic signed [OSC_W-1:0] sat18(input logic signed [39:0] v);
    if (v > 40'(Q17_MAX)) begin
      return Q17_MAX;
    end else if (v < 40'(Q17_MIN)) begin
      return Q17_MIN;
    end else begin
      return signed'(v[OSC_W-1:0]);
    end
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [39:0] v);
    if (v > 40'(Q15_MAX)) begin
      return Q15_MAX;
    end else if (v < 40'(Q15_MIN)) begin
      return Q15_MIN;
    end else begin
      return signed'(v[SAMPLE_W-1:0]);
    end
  endfunction

endpackage

FILE: rtl/complex_mixer_halfband_decimator.sv
// Top level of the complex NCO mixer with 11-tap halfband decimate-by-2.
// Depends on cmhd_pkg, cmhd_front, cmhd_queue and cmhd_back.
`timescale 1ns / 1ps

// Usage:
// Samples enter on the s_axis stream (in_i low half, in_q high half of
// tdata). Every second accepted sample yields one filtered result on the
// m_axis stream (out_i low half, out_q high half). The oscillator step is
// written on the cfg port (index 0 step_cos, index 1 step_sin, others are
// ignored); cfg_ready_o is always high and writes belong to idle periods.
// A front stage tags each sample, a two-entry queue holds tagged samples,
// and a back sequencer processes one sample at a time: multiply and
// accumulate for the first sample of a pair, and for the second also
// filter multiply and sum, plus oscillator renormalization (square,
// gain, multiply, apply) at the first sample of every BLOCK_SIZE
// samples. The sustained rate is set by the back sequencer, which starts
// no new sample until it is through with the last one.
// Reset restores the oscillator to one, the step to zero phase, clears the
// delay line and pair phase, and starts a new renormalization block.
// When the receiver stalls, the result waits in the output register; the
// back finishes the next result into its filter stage and then holds,
// while the queue keeps taking up to two more samples.

module complex_mixer_halfband_decimator #(
  parameter int unsigned BLOCK_SIZE = cmhd_pkg::BLOCK_SIZE_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [31:0]                    s_axis_tdata,   // in_i [15:0], in_q [31:16]
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [31:0]                    m_axis_tdata,   // out_i [15:0], out_q [31:16]
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [cmhd_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [cmhd_pkg::OSC_W-1:0]     cfg_data_i
);

  cmhd_pkg::item_t   push_item, head_item;
  cmhd_pkg::cfg_wr_t cfg_wr;
  logic              push, push_ready, head_valid, pop;

  assign cfg_ready_o  = 1'b1;
  assign cfg_wr.valid = cfg_valid_i;
  assign cfg_wr.index = cfg_index_i;
  assign cfg_wr.data  = cfg_data_i;

  cmhd_front #(
    .BLOCK_SIZE (BLOCK_SIZE)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .push_o        (push),
    .push_ready_i  (push_ready),
    .item_o        (push_item)
  );

  cmhd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (push),
    .wr_ready_o (push_ready),
    .wr_item_i  (push_item),
    .rd_valid_o (head_valid),
    .rd_pop_i   (pop),
    .rd_item_o  (head_item)
  );

  cmhd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_wr),
    .head_valid_i  (head_valid),
    .head_i        (head_item),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

FILE: rtl/cmhd_front.sv
// Input side: accepts samples and tags each with its renormalize and emit flags.
// Depends on cmhd_pkg.
`timescale 1ns / 1ps

module cmhd_front #(
  parameter int unsigned BLOCK_SIZE = cmhd_pkg::BLOCK_SIZE_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [31:0]         s_axis_tdata,   // in_i [15:0], in_q [31:16]
  output logic                push_o,
  input  logic                push_ready_i,
  output cmhd_pkg::item_t     item_o
);

  localparam int unsigned CNT_W = $clog2(BLOCK_SIZE);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             phase_q, phase_d;
  logic             xfer;

  assign s_axis_tready = push_ready_i;
  assign push_o        = s_axis_tvalid;
  assign xfer          = s_axis_tvalid && push_ready_i;

  always_comb begin
    item_o.in_i   = signed'(s_axis_tdata[15:0]);
    item_o.in_q   = signed'(s_axis_tdata[31:16]);
    // A new renormalization block starts whenever the counter is zero, after reset or a wrap.
    item_o.renorm = (cnt_q == '0);
    item_o.emit   = phase_q;
  end

  always_comb begin
    cnt_d   = cnt_q;
    phase_d = phase_q;
    if (xfer) begin
      phase_d = !phase_q;
      cnt_d   = (cnt_q == CNT_W'(BLOCK_SIZE - 1)) ? '0 : cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      phase_q <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      phase_q <= phase_d;
    end
  end

endmodule

FILE: rtl/cmhd_queue.sv
// Two-entry queue of classified samples between the front and the back.
// Depends on cmhd_pkg.
`timescale 1ns / 1ps

module cmhd_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_valid_i,
  output logic            wr_ready_o,
  input  cmhd_pkg::item_t wr_item_i,
  output logic            rd_valid_o,
  input  logic            rd_pop_i,
  output cmhd_pkg::item_t rd_item_o
);

  cmhd_pkg::item_t                 mem_q [cmhd_pkg::QDEPTH];
  logic [cmhd_pkg::QPTR_W-1:0]     wr_ptr_q, rd_ptr_q;
  logic [cmhd_pkg::QCNT_W-1:0]     cnt_q;
  logic                            push, pop;

  assign wr_ready_o = (cnt_q != cmhd_pkg::QCNT_W'(cmhd_pkg::QDEPTH));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_item_o  = mem_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_pop_i && rd_valid_o;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + cmhd_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + cmhd_pkg::QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + cmhd_pkg::QCNT_W'(1);
        2'b01:   cnt_q <= cnt_q - cmhd_pkg::QCNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

FILE: rtl/cmhd_back.sv
// Processing side: oscillator renormalization, mixing, oscillator step,
// delay line, halfband filter and output register. Depends on cmhd_pkg.
`timescale 1ns / 1ps

module cmhd_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmhd_pkg::cfg_wr_t cfg_i,
  input  logic              head_valid_i,
  input  cmhd_pkg::item_t   head_i,
  output logic              pop_o,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [31:0]       m_axis_tdata    // out_i [15:0], out_q [31:16]
);

  localparam int unsigned TAPS = cmhd_pkg::TAP_COUNT;

  cmhd_pkg::state_e state_q, state_d;

  logic signed [17:0] step_cos_q, step_sin_q;
  logic signed [17:0] osc_re_q, osc_im_q;
  logic signed [17:0] dl_q [2][TAPS];

  // Mixer and step products.
  logic signed [33:0] mrr_q, mqi_q, mri_q, mqr_q;
  logic signed [35:0] src_q, sis_q, srs_q, sic_q;
  // Renormalization.
  logic signed [35:0] sq_re_q, sq_im_q;
  logic        [18:0] gain_q;
  logic signed [37:0] gre_q, gim_q;
  logic signed [37:0] mag2, gsum, gsum_sh;
  // Filter partial products, one set per channel.
  logic signed [36:0] fe_q [2];
  logic signed [36:0] fn_q [2];
  logic signed [36:0] fs_q [2];
  logic signed [36:0] fm_q [2];

  logic               out_valid_q;
  logic signed [15:0] out_q [2];
  logic               out_free, load_out;

  logic signed [17:0] mix [2];
  logic signed [15:0] fir_y [2];

  assign out_free      = !out_valid_q || m_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q[1], out_q[0]};

  always_comb begin
    mag2    = 38'(sq_re_q) + 38'(sq_im_q);
    gsum    = 38'sd34359738368 - mag2 + 38'sd65536;
    gsum_sh = gsum >>> 17;
  end

  always_comb begin
    mix[0] = cmhd_pkg::sat18((40'(mrr_q) - 40'(mqi_q) + 40'sd16384) >>> 15);
    mix[1] = cmhd_pkg::sat18((40'(mri_q) + 40'(mqr_q) + 40'sd16384) >>> 15);
    for (int c = 0; c < 2; c++) begin
      fir_y[c] = cmhd_pkg::sat16((40'(fe_q[c]) + 40'(fn_q[c]) + 40'(fs_q[c])
                                  + 40'(fm_q[c]) + 40'sd262144) >>> 19);
    end
  end

  // Sequencer: one sample at a time, renormalizing first when flagged.
  always_comb begin
    state_d  = state_q;
    pop_o    = 1'b0;
    load_out = 1'b0;
    case (state_q)
      cmhd_pkg::ST_IDLE: begin
        if (head_valid_i) begin
          state_d = head_i.renorm ? cmhd_pkg::ST_RN_SQ : cmhd_pkg::ST_MUL;
        end
      end
      cmhd_pkg::ST_RN_SQ:    state_d = cmhd_pkg::ST_RN_GAIN;
      cmhd_pkg::ST_RN_GAIN:  state_d = cmhd_pkg::ST_RN_MUL;
      cmhd_pkg::ST_RN_MUL:   state_d = cmhd_pkg::ST_RN_APPLY;
      cmhd_pkg::ST_RN_APPLY: state_d = cmhd_pkg::ST_MUL;
      cmhd_pkg::ST_MUL:      state_d = cmhd_pkg::ST_ACC;
      cmhd_pkg::ST_ACC: begin
        pop_o   = 1'b1;
        state_d = head_i.emit ? cmhd_pkg::ST_FIR_MUL : cmhd_pkg::ST_IDLE;
      end
      cmhd_pkg::ST_FIR_MUL:  state_d = cmhd_pkg::ST_FIR_SUM;
      cmhd_pkg::ST_FIR_SUM: begin
        if (out_free) begin
          load_out = 1'b1;
          state_d  = cmhd_pkg::ST_IDLE;
        end
      end
      default: state_d = cmhd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cmhd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_cos_q <= cmhd_pkg::Q17_MAX;
      step_sin_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        cmhd_pkg::CFG_STEP_COS: step_cos_q <= signed'(cfg_i.data);
        cmhd_pkg::CFG_STEP_SIN: step_sin_q <= signed'(cfg_i.data);
        default: ;
      endcase
    end
  end

  // Unreset product registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      cmhd_pkg::ST_RN_SQ: begin
        sq_re_q <= osc_re_q * osc_re_q;
        sq_im_q <= osc_im_q * osc_im_q;
      end
      cmhd_pkg::ST_RN_GAIN: begin
        gain_q <= gsum_sh[18:0];
      end
      cmhd_pkg::ST_RN_MUL: begin
        gre_q <= osc_re_q * signed'({1'b0, gain_q});
        gim_q <= osc_im_q * signed'({1'b0, gain_q});
      end
      cmhd_pkg::ST_MUL: begin
        mrr_q <= head_i.in_i * osc_re_q;
        mqi_q <= head_i.in_q * osc_im_q;
        mri_q <= head_i.in_i * osc_im_q;
        mqr_q <= head_i.in_q * osc_re_q;
        src_q <= osc_re_q * step_cos_q;
        sis_q <= osc_im_q * step_sin_q;
        srs_q <= osc_re_q * step_sin_q;
        sic_q <= osc_im_q * step_cos_q;
      end
      cmhd_pkg::ST_FIR_MUL: begin
        for (int c = 0; c < 2; c++) begin
          fe_q[c] <= 37'(cmhd_pkg::COEF_EDGE) * (37'(dl_q[c][0]) + 37'(dl_q[c][10]));
          fn_q[c] <= 37'(cmhd_pkg::COEF_NEAR) * (37'(dl_q[c][2]) + 37'(dl_q[c][8]));
          fs_q[c] <= 37'(cmhd_pkg::COEF_SIDE) * (37'(dl_q[c][4]) + 37'(dl_q[c][6]));
          fm_q[c] <= 37'(dl_q[c][5]) <<< cmhd_pkg::COEF_MID_SHIFT;
        end
      end
      default: ;
    endcase
  end

  // Oscillator and delay line state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      osc_re_q <= cmhd_pkg::Q17_MAX;
      osc_im_q <= '0;
      for (int c = 0; c < 2; c++) begin
        for (int k = 0; k < TAPS; k++) begin
          dl_q[c][k] <= '0;
        end
      end
    end else begin
      case (state_q)
        cmhd_pkg::ST_RN_APPLY: begin
          osc_re_q <= cmhd_pkg::sat18((40'(gre_q) + 40'sd65536) >>> 17);
          osc_im_q <= cmhd_pkg::sat18((40'(gim_q) + 40'sd65536) >>> 17);
        end
        cmhd_pkg::ST_ACC: begin
          osc_re_q <= cmhd_pkg::sat18((40'(src_q) - 40'(sis_q) + 40'sd65536) >>> 17);
          osc_im_q <= cmhd_pkg::sat18((40'(srs_q) + 40'(sic_q) + 40'sd65536) >>> 17);
          for (int c = 0; c < 2; c++) begin
            dl_q[c][0] <= mix[c];
            for (int k = 1; k < TAPS; k++) begin
              dl_q[c][k] <= dl_q[c][k-1];
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q[0] <= fir_y[0];
      out_q[1] <= fir_y[1];
    end
  end

endmodule

FILE: rtl/cmhd_checker.sv
// Port-level assertions for the mixer and decimator, bound to the top level.
// Depends on complex_mixer_halfband_decimator.
`timescale 1ns / 1ps

module cmhd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  // Completed input pairs whose result has not yet been transferred.
  logic       in_par_q;
  logic [7:0] pend_q;
  logic       in_xfer, out_xfer, pair_done;

  assign in_xfer   = s_axis_tvalid && s_axis_tready;
  assign out_xfer  = m_axis_tvalid && m_axis_tready;
  assign pair_done = in_xfer && in_par_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_par_q <= 1'b0;
      pend_q   <= '0;
    end else begin
      if (in_xfer) begin
        in_par_q <= !in_par_q;
      end
      case ({pair_done, out_xfer})
        2'b10:   pend_q <= pend_q + 8'd1;
        2'b01:   pend_q <= pend_q - 8'd1;
        default: pend_q <= pend_q;
      endcase
    end
  end

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result valid dropped while stalled");

  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result data changed while stalled");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> pend_q != 8'd0)
    else $error("result shown without a completed input pair");

  // The output flag may still be unknown at the very first edge of reset.
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> m_axis_tvalid !== 1'b1)
    else $error("result valid during reset");

endmodule

bind complex_mixer_halfband_decimator cmhd_checker u_cmhd_checker (.*);
